// ===== rtl/ib26_pkg.sv =====
package ib26_pkg;

  // Magnitude and division step geometry
  localparam int MAG_W       = 64;
  localparam int CHUNK_W     = 16;
  localparam int REM_W       = 5;
  localparam int NUM_W       = REM_W + CHUNK_W;
  localparam int STEPS       = MAG_W / CHUNK_W;
  localparam int STEP_W      = $clog2(STEPS);
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 26;
  localparam int PROD_W      = NUM_W + RECIP_W;

  // ceil(2^26 / 26): exact quotient for every 21-bit numerator
  localparam logic [RECIP_W-1:0] RECIP = 22'd2581111;
  localparam logic [NUM_W-1:0]   RADIX = 21'd26;

  // Digit store: a 64-bit magnitude never needs more than 14 base-26 digits
  localparam int DIGIT_SLOTS = 16;
  localparam int DIG_IDX_W   = $clog2(DIGIT_SLOTS);

  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LENGTH = 2'd2;
  localparam int CFG_DATA_W = 8;

  localparam logic [7:0] LETTER_BASE_RST   = 8'd97;
  localparam logic [5:0] MIN_DIGITS_RST    = 6'd0;
  localparam logic [6:0] BUFFER_LENGTH_RST = 7'd40;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SETUP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             digit_valid;
    logic             done;
    logic [REM_W-1:0] digit;
  } div_status_t;

endpackage

// ===== rtl/ib26_div_unit.sv =====
module ib26_div_unit
  import ib26_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] mag_in,
  output div_status_t      status
);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [MAG_W-1:0]  mag;
  logic [REM_W-1:0]  rem;

  logic [NUM_W-1:0]   num;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quot;
  logic [REM_W-1:0]   rem_next;
  logic [MAG_W-1:0]   mag_next;
  logic               last_step;

  // One 16-bit long-division step by 26, top chunk first; the quotient
  // chunk rotates in at the bottom so the full quotient is in place after
  // the last step.
  always_comb begin
    num       = {rem, mag[MAG_W-1 -: CHUNK_W]};
    prod      = PROD_W'(num) * PROD_W'(RECIP);
    quot      = prod[RECIP_SHIFT +: CHUNK_W];
    rem_next  = REM_W'(num - NUM_W'(quot) * RADIX);
    mag_next  = {mag[MAG_W-CHUNK_W-1:0], quot};
    last_step = (step == STEP_W'(STEPS - 1));
  end

  assign status.digit_valid = active & last_step;
  assign status.digit       = rem_next;
  assign status.done        = active & last_step & (mag_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (start) begin
      active <= 1'b1;
      step   <= '0;
    end else if (active) begin
      step <= step + 1'b1;
      if (status.done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag <= mag_in;
      rem <= '0;
    end else if (active) begin
      mag <= mag_next;
      rem <= last_step ? '0 : rem_next;
    end
  end

endmodule

// ===== rtl/integer_to_base26_text_unit.sv =====
// Base-26 text converter. Each request carries a 64-bit value and a signed
// flag; a negative signed value is converted by magnitude and gets a leading
// '-' (45). Digits go out most significant first as letter_base + digit
// (mod 256), left-padded with zero digits up to min_digits (clamped to
// MAX_CHARS-1), one character per result, cut off at buffer_length. The
// final result has last set and carries the full text length and an
// overflow flag when the text did not fit; with buffer_length zero a single
// result with char_valid low is sent. The block takes one request at a time
// and stalls its input until the final result is loaded into the output
// register. A request has 1 to 14 digits and gives at least one result.
// The digits come from the single divide-by-26 unit, which retires one
// 16-bit chunk of the 64-bit magnitude per cycle; the results leave through
// the single output register, which sends one character per cycle while the
// receiver does not stall. Configuration writes are registered and must be
// made while idle.
module integer_to_base26_text_unit
  import ib26_pkg::*;
#(
  parameter int MAX_CHARS = 40,
  localparam int TLW      = $clog2(MAX_CHARS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MAG_W-1:0]      value,
  input  logic                  is_signed,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            character,
  output logic                  char_valid,
  output logic                  last,
  output logic [TLW-1:0]        text_length,
  output logic                  overflow,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [5:0] PREC_MAX = 6'(MAX_CHARS - 1);

  // Configuration registers
  logic [7:0] letter_base;
  logic [5:0] min_digits;
  logic [6:0] buffer_length;

  state_t state, state_next;

  // Request bookkeeping
  logic                 neg;
  logic                 neg_in;
  logic [MAG_W-1:0]     mag_in;
  logic [DIG_IDX_W-1:0] nd;
  logic [4:0]           digs [DIGIT_SLOTS];

  // Emit bookkeeping
  logic                 sign_pend;
  logic [5:0]           pad_cnt;
  logic [DIG_IDX_W-1:0] didx;
  logic [TLW-1:0]       len;
  logic [TLW-1:0]       emit_cnt;
  logic [TLW-1:0]       k;

  // Control
  logic        start;
  logic        slot_free;
  logic        emit_now;
  logic        fin;
  div_status_t div_status;

  // Setup arithmetic
  logic [5:0]     prec;
  logic [5:0]     pad_calc;
  logic [TLW-1:0] len_calc;
  logic [TLW-1:0] emit_calc;
  logic [7:0]     char_calc;

  // Magnitude of a negative signed value; the most negative value maps to
  // 2^63, which is exactly what the unsigned negate gives.
  assign neg_in = is_signed & value[MAG_W-1];
  assign mag_in = neg_in ? (~value + 1'b1) : value;

  ib26_div_unit u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mag_in (mag_in),
    .status (div_status)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_DIV;
      S_DIV:   if (div_status.done) state_next = S_SETUP;
      S_SETUP: state_next = S_EMIT;
      S_EMIT:  if (slot_free && fin) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  assign slot_free = ~out_valid | ~out_stall;
  always_comb begin
    in_stall = 1'b1;
    start    = 1'b0;
    emit_now = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        start    = in_valid;
      end
      S_EMIT:  emit_now = slot_free;
      default: ;
    endcase
  end

  // Text layout once the digit count is known
  always_comb begin
    prec      = (min_digits > PREC_MAX) ? PREC_MAX : min_digits;
    pad_calc  = (prec > 6'(nd)) ? (prec - 6'(nd)) : 6'd0;
    len_calc  = TLW'(neg) + TLW'(pad_calc) + TLW'(nd);
    emit_calc = (7'(len_calc) > buffer_length) ? TLW'(buffer_length) : len_calc;
  end

  // Sign first, then pad digits, then the stored digits top down
  always_comb begin
    priority if (sign_pend) begin
      char_calc = CHAR_MINUS;
    end else if (pad_cnt != '0) begin
      char_calc = letter_base;
    end else begin
      char_calc = 8'(letter_base + 8'(digs[didx]));
    end
  end

  // Final result: the last character, or a lone result with no character for an empty buffer
  assign fin = (emit_cnt == '0) || (TLW'(k + 1'b1) == emit_cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      letter_base   <= LETTER_BASE_RST;
      min_digits    <= MIN_DIGITS_RST;
      buffer_length <= BUFFER_LENGTH_RST;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LETTER_BASE:   letter_base   <= cfg_data;
          CFG_MIN_DIGITS:    min_digits    <= cfg_data[5:0];
          CFG_BUFFER_LENGTH: buffer_length <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture request, collect digits least significant first
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= neg_in;
      nd  <= '0;
    end else if (div_status.digit_valid) begin
      digs[nd] <= div_status.digit;
      nd       <= nd + 1'b1;
    end
  end

  // Walk the text one character per loaded result
  always_ff @(posedge clk) begin
    if (state == S_SETUP) begin
      sign_pend <= neg;
      pad_cnt   <= pad_calc;
      didx      <= nd - 1'b1;
      len       <= len_calc;
      emit_cnt  <= emit_calc;
      k         <= '0;
    end else if (emit_now) begin
      k <= k + 1'b1;
      priority if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (pad_cnt != '0) begin
        pad_cnt <= pad_cnt - 1'b1;
      end else begin
        didx <= didx - 1'b1;
      end
    end
  end

  // Output register: hold while stalled, load the next result when free
  always_ff @(posedge clk) begin
    if (emit_now) begin
      if (emit_cnt == '0) begin
        character  <= 8'd0;
        char_valid <= 1'b0;
      end else begin
        character  <= char_calc;
        char_valid <= 1'b1;
      end
      last        <= fin;
      text_length <= fin ? len : '0;
      overflow    <= fin & (emit_cnt < len);
    end
  end

endmodule

// ===== tb/integer_to_base26_text_unit_tb.sv =====
`timescale 1ns / 1ps

module integer_to_base26_text_unit_tb;
  import ib26_pkg::*;

  localparam int MAX_CHARS = 40;
  localparam int LEN_W = $clog2(MAX_CHARS + 1);
  // Index 3 maps to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  // The longest request stays well under the quiet limit below even with the
  // long receiver hold-off on top.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CFG_SETTLE = 8;
  localparam int END_SETTLE = 100;
  localparam int IDLE_PERCENT = 27;

  typedef struct {
    logic [7:0]       character;
    logic             char_valid;
    logic             last;
    logic [LEN_W-1:0] text_length;
    logic             overflow;
  } text_beat_t;

  // Tracks the register file and the characters each request must produce.
  class base26_text_checker;
    logic [7:0] letter_base = LETTER_BASE_RST;
    logic [5:0] min_digits = MIN_DIGITS_RST;
    logic [6:0] buffer_length = BUFFER_LENGTH_RST;
    text_beat_t expected_chars[$];
    int errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LETTER_BASE:   letter_base = data[7:0];
        CFG_MIN_DIGITS:    min_digits = data[5:0];
        CFG_BUFFER_LENGTH: buffer_length = data[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    // Spell the request in base 26 and queue one beat per emitted character.
    function void note_request(logic [MAG_W-1:0] v, logic s);
      logic [MAG_W-1:0] mag;
      logic [4:0] digits[$];
      logic [7:0] chars[$];
      logic neg;
      int width;
      int emit;
      text_beat_t beat;
      neg = s && v[MAG_W-1];
      mag = neg ? (64'd0 - v) : v;
      do begin
        digits.push_front(5'(mag % 64'd26));
        mag = mag / 64'd26;
      end while (mag != 0);
      width = (min_digits > MAX_CHARS - 1) ? MAX_CHARS - 1 : int'(min_digits);
      if (neg) chars.push_back(CHAR_MINUS);
      for (int k = digits.size(); k < width; k++) chars.push_back(letter_base);
      foreach (digits[k]) chars.push_back(8'(letter_base + 8'(digits[k])));
      emit = (chars.size() > buffer_length) ? int'(buffer_length) : chars.size();
      if (emit == 0) begin
        beat = '{8'd0, 1'b0, 1'b1, LEN_W'(chars.size()), 1'b1};
        expected_chars.push_back(beat);
      end
      for (int k = 0; k < emit; k++) begin
        beat.character = chars[k];
        beat.char_valid = 1'b1;
        beat.last = (k == emit - 1);
        beat.text_length = beat.last ? LEN_W'(chars.size()) : '0;
        beat.overflow = beat.last && (emit < chars.size());
        expected_chars.push_back(beat);
      end
    endfunction

    function void report(string field, logic [7:0] exp_val, logic [7:0] got_val);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, got_val);
    endfunction

    function void check_char(text_beat_t got);
      text_beat_t exp_beat;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: character %0d arrived with no request pending, expected nothing",
                   $time, got.character);
        return;
      end
      exp_beat = expected_chars.pop_front();
      if (got.character !== exp_beat.character)
        report("character", exp_beat.character, got.character);
      if (got.char_valid !== exp_beat.char_valid)
        report("char_valid", exp_beat.char_valid, got.char_valid);
      if (got.last !== exp_beat.last)
        report("last", exp_beat.last, got.last);
      if (got.text_length !== exp_beat.text_length)
        report("text_length", exp_beat.text_length, got.text_length);
      if (got.overflow !== exp_beat.overflow)
        report("overflow", exp_beat.overflow, got.overflow);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [MAG_W-1:0] value = '0;
  logic is_signed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] character;
  logic char_valid;
  logic last;
  logic [LEN_W-1:0] text_length;
  logic overflow;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Written by the stimulus only; the receiver reacts on its own timing.
  int hold_off_req = 0;
  bit no_idle = 1'b0;
  int hold_off_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  base26_text_checker text_chk = new;

  integer_to_base26_text_unit #(.MAX_CHARS(MAX_CHARS)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .is_signed(is_signed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .character(character),
    .char_valid(char_valid),
    .last(last),
    .text_length(text_length),
    .overflow(overflow),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: stall at random, hold off for a long stretch on demand,
  // and stay open while the stimulus asks for a quiet stretch.
  always @(negedge clk) begin
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Sample both channels and the config port at the rising edge, check every
  // accepted character, and end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) text_chk.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) text_chk.note_request(value, is_signed);
      if (out_valid && !out_stall)
        text_chk.check_char('{character, char_valid, last, text_length, overflow});
    end
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Valid stays
  // high on return so back-to-back requests need no extra edge.
  task automatic offer_request(input logic [MAG_W-1:0] v, input logic s);
    @(negedge clk);
    in_valid <= 1'b1;
    value <= v;
    is_signed <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_requests(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Drop valid and wait until every expected character has come back.
  task automatic wait_for_text_drain(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (text_chk.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Write all three registers plus the unused index, block idle.
  task automatic program_regs(input logic [7:0] letter, input logic [7:0] digits_min,
                              input logic [7:0] buf_len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LETTER_BASE;
    cfg_data <= letter;
    @(negedge clk);
    cfg_index <= CFG_MIN_DIGITS;
    cfg_data <= digits_min;
    @(negedge clk);
    cfg_index <= CFG_BUFFER_LENGTH;
    cfg_data <= buf_len;
    @(negedge clk);
    cfg_index <= CFG_UNUSED_INDEX;
    cfg_data <= CFG_DATA_W'($urandom_range(255));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mix short values, values near powers of 26, small negatives, corner
  // patterns and full-width random patterns.
  task automatic pick_value(output logic [MAG_W-1:0] v, output logic s);
    logic [MAG_W-1:0] p;
    int k;
    s = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: v = MAG_W'($urandom_range(30));
      1: begin
        p = 64'd1;
        k = $urandom_range(13);
        repeat (k) p = p * 64'd26;
        v = p + MAG_W'($urandom_range(2)) - 64'd1;
      end
      2: begin
        v = 64'd0 - MAG_W'($urandom_range(1, 700));
        s = 1'b1;
      end
      3: case ($urandom_range(3))
        0: v = '0;
        1: v = '1;
        2: v = 64'h8000_0000_0000_0000;
        default: v = 64'h7FFF_FFFF_FFFF_FFFF;
      endcase
      4, 5: v = {$urandom, $urandom} >> $urandom_range(63);
      default: v = {$urandom, $urandom};
    endcase
  endtask

  // Run a batch of random requests; optionally trigger the long receiver
  // hold-off or a full drain part way through.
  task automatic run_random(input int count, input int hold_at, input int drain_at);
    logic [MAG_W-1:0] v;
    logic s;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_off_req++;
      if (n == drain_at) wait_for_text_drain(0);
      if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        pause_requests($urandom_range(1, 6));
      pick_value(v, s);
      offer_request(v, s);
    end
  endtask

  initial begin
    logic [MAG_W:0] directed[] = '{
      {1'b0, 64'd0}, {1'b1, 64'd0}, {1'b0, 64'd25}, {1'b0, 64'd26},
      {1'b0, 64'd675}, {1'b0, 64'd676},
      {1'b0, 64'hFFFF_FFFF_FFFF_FFFF}, {1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      {1'b1, 64'h8000_0000_0000_0000}, {1'b0, 64'h8000_0000_0000_0000},
      {1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
      {1'b0, 64'd2481152873203736576}, {1'b0, 64'd2481152873203736575},
      {1'b1, 64'hFFFF_FFFF_FFFF_FFE6}, {1'b1, 64'd12345}
    };
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero, digit boundaries, 14-digit and most negative values.
    foreach (directed[i]) offer_request(directed[i][MAG_W-1:0], directed[i][MAG_W]);
    wait_for_text_drain(CFG_SETTLE);

    // Upper-case letters with a stretch of no idling on either side.
    program_regs(8'd65, 8'd0, 8'd40);
    no_idle = 1'b1;
    run_random(40, -1, -1);
    wait_for_text_drain(CFG_SETTLE);
    no_idle = 1'b0;

    // Zero buffer length: one empty beat per request.
    program_regs(8'd0, 8'd0, 8'd0);
    run_random(20, -1, -1);
    wait_for_text_drain(CFG_SETTLE);

    // All-ones writes: min_digits 63 clamps to 39, buffer length 127.
    program_regs(8'hFF, 8'hFF, 8'hFF);
    run_random(40, -1, -1);
    wait_for_text_drain(CFG_SETTLE);

    // Letter codes wrap past 255; long receiver hold-off fills the block.
    program_regs(8'd250, 8'd39, 8'd64);
    run_random(40, 5, -1);
    wait_for_text_drain(CFG_SETTLE);

    // Short buffer forces truncation; sender pauses for a full drain midway.
    program_regs(8'd48, 8'd10, 8'd5);
    run_random(40, -1, 20);
    wait_for_text_drain(CFG_SETTLE);

    // Random settings, biased toward buffer lengths near the text lengths.
    repeat (5) begin
      program_regs(8'($urandom_range(255)), 8'($urandom_range(63)),
                   $urandom_range(1) ? 8'($urandom_range(20)) : 8'($urandom_range(127)));
      run_random(40, -1, -1);
      wait_for_text_drain(CFG_SETTLE);
    end

    wait_for_text_drain(END_SETTLE);
    if (text_chk.errors == 0 && text_chk.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
